/* hdl/crq_pkg.sv */
package crq_pkg;

  localparam int LEVEL_W   = 16;
  localparam int ID_PORT_W = 8;
  localparam int STATUS_W  = 3;
  localparam int OUT_LVL_W = 8;

  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  localparam logic [OUT_LVL_W-1:0] LEVEL_MAX = 8'd128;

  localparam logic REQ_PLAY    = 1'b0;
  localparam logic REQ_SERVICE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP_RD,
    S_POP_DATA,
    S_DONE
  } crq_state_t;

  // Q8.8 level times 128, truncated and clamped to 0..128.
  function automatic logic [OUT_LVL_W-1:0] scale_level(input logic signed [LEVEL_W-1:0] lv);
    logic [OUT_LVL_W-1:0] r;
    if (lv[LEVEL_W-1]) begin
      r = '0;
    end else if (|lv[LEVEL_W-2:8]) begin
      r = LEVEL_MAX;
    end else begin
      r = lv[8:1];
    end
    return r;
  endfunction

endpackage

/* hdl/crq_store.sv */
module crq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/coalescing_request_queue_top.sv */
// Channel   Handshake              Payload
// request   req_valid / req_stall  req_type, play_id, level
// response  rsp_valid / rsp_stall  status, out_id, out_level
//
// A play request scans the stored entries head to tail, one entry per cycle
// through the single read port of the entry memory.
// A service beat reads the head from memory (POP_RD), then forms the result
// (POP_DATA); an empty queue skips the memory read.
// Reset clears the ring pointers and the handshake state; entry memory is
// not cleared, since only written entries are ever compared or returned.
// One request is in flight at a time; a finished result waits in the
// response register, and the next request beat is taken while it waits.
module coalescing_request_queue_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic                                  req_type,
  input  logic [crq_pkg::ID_PORT_W-1:0]         play_id,
  input  logic signed [crq_pkg::LEVEL_W-1:0]    level,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic [crq_pkg::STATUS_W-1:0]          status,
  output logic [crq_pkg::ID_PORT_W-1:0]         out_id,
  output logic [crq_pkg::OUT_LVL_W-1:0]         out_level
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int DW = ID_WIDTH + crq_pkg::LEVEL_W;
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] i);
    return (i == LAST) ? '0 : i + PW'(1);
  endfunction

  crq_pkg::crq_state_t state, state_next;

  logic [PW-1:0] head, tail;
  logic [PW-1:0] scan_idx, cmp_idx;
  logic          cmp_pend;

  logic [ID_WIDTH-1:0]               req_id;
  logic signed [crq_pkg::LEVEL_W-1:0] req_level;
  logic [ID_WIDTH-1:0]               in_id;

  logic [crq_pkg::STATUS_W-1:0]  res_status;
  logic [crq_pkg::ID_PORT_W-1:0] res_id;
  logic [crq_pkg::OUT_LVL_W-1:0] res_level;

  logic          mem_we;
  logic [PW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  logic [ID_WIDTH-1:0]                rd_id;
  logic signed [crq_pkg::LEVEL_W-1:0] rd_level;
  logic [crq_pkg::ID_PORT_W-1:0]      rd_id_port;

  logic req_take, rsp_free, empty, full, hit, scan_end;

  assign req_stall = (state != crq_pkg::S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign empty     = (head == tail);
  assign full      = (next_slot(tail) == head);

  assign rd_id    = mem_rdata[DW-1:crq_pkg::LEVEL_W];
  assign rd_level = $signed(mem_rdata[crq_pkg::LEVEL_W-1:0]);

  // Truncate or zero-extend the identifier to ID_WIDTH bits, and back for the port.
  generate
    if (ID_WIDTH >= crq_pkg::ID_PORT_W) begin : g_id_wide
      assign in_id      = ID_WIDTH'(play_id);
      assign rd_id_port = rd_id[crq_pkg::ID_PORT_W-1:0];
    end else begin : g_id_narrow
      assign in_id      = play_id[ID_WIDTH-1:0];
      assign rd_id_port = crq_pkg::ID_PORT_W'(rd_id);
    end
  endgenerate

  // The entry read in the previous cycle is compared now.
  assign hit      = cmp_pend && (rd_id == req_id);
  assign scan_end = !hit && (scan_idx == tail);

  crq_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      crq_pkg::S_IDLE: begin
        if (req_take) begin
          if (req_type == crq_pkg::REQ_PLAY) begin
            state_next = crq_pkg::S_SCAN;
          end else if (empty) begin
            state_next = crq_pkg::S_DONE;
          end else begin
            state_next = crq_pkg::S_POP_RD;
          end
        end
      end
      crq_pkg::S_SCAN: begin
        if (hit || scan_end) begin
          state_next = crq_pkg::S_DONE;
        end
      end
      crq_pkg::S_POP_RD:   state_next = crq_pkg::S_POP_DATA;
      crq_pkg::S_POP_DATA: state_next = crq_pkg::S_DONE;
      crq_pkg::S_DONE: begin
        if (rsp_free) begin
          state_next = crq_pkg::S_IDLE;
        end
      end
      default: state_next = crq_pkg::S_IDLE;
    endcase
  end

  // Memory port controls: read the scan pointer while scanning, else the head.
  always_comb begin
    mem_raddr = (state == crq_pkg::S_SCAN) ? scan_idx : head;
    mem_we    = 1'b0;
    mem_waddr = tail;
    mem_wdata = {req_id, req_level};
    if (state == crq_pkg::S_SCAN) begin
      if (hit) begin
        mem_we    = (req_level > rd_level);
        mem_waddr = cmp_idx;
      end else if (scan_end && !full) begin
        mem_we    = 1'b1;
        mem_waddr = tail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= crq_pkg::S_IDLE;
      head     <= '0;
      tail     <= '0;
      cmp_pend <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        crq_pkg::S_IDLE: begin
          if (req_take) begin
            req_id     <= in_id;
            req_level  <= level;
            scan_idx   <= head;
            cmp_pend   <= 1'b0;
            res_status <= crq_pkg::ST_EMPTY;
            res_id     <= '0;
            res_level  <= '0;
          end
        end
        crq_pkg::S_SCAN: begin
          if (hit) begin
            res_status <= crq_pkg::ST_MERGED;
          end else if (scan_end) begin
            if (full) begin
              res_status <= crq_pkg::ST_FULL;
            end else begin
              res_status <= crq_pkg::ST_APPENDED;
              tail       <= next_slot(tail);
            end
          end else begin
            // advance: issue the next read, compare this one next cycle
            cmp_pend <= 1'b1;
            cmp_idx  <= scan_idx;
            scan_idx <= next_slot(scan_idx);
          end
        end
        crq_pkg::S_POP_RD: begin
        end
        crq_pkg::S_POP_DATA: begin
          res_status <= crq_pkg::ST_POPPED;
          res_id     <= rd_id_port;
          res_level  <= crq_pkg::scale_level(rd_level);
          head       <= next_slot(head);
        end
        crq_pkg::S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Response register: load on the way out of DONE, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == crq_pkg::S_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == crq_pkg::S_DONE && rsp_free) begin
      status    <= res_status;
      out_id    <= res_id;
      out_level <= res_level;
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (head <= LAST) && (tail <= LAST))
    else $error("ring pointer beyond queue depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == crq_pkg::S_POP_DATA) |-> (head != tail))
    else $error("pop from an empty queue");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == crq_pkg::S_DONE))
    else $error("response raised outside completion");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    (state == crq_pkg::S_SCAN && mem_we && !hit) |-> !full)
    else $error("append into a full queue");

endmodule
